// ----- hdl/stkpc_pkg.sv -----
package stkpc_pkg;

    localparam int ValW = 11;
    localparam int NteW = ValW + 1;

    typedef logic [ValW-1:0] t_val;
    typedef logic [NteW-1:0] t_nte;

endpackage

// ----- hdl/stkpc_ram.sv -----
module stkpc_ram
    import stkpc_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_val              i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_val              o_rd_data
);

    t_val r_mem [DEPTH];
    t_val r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/stack_permutation_checker_core.sv -----
// stack permutation checker
// decides whether a wanted exit order can leave a single lifo stack that is
// fed the items 1..n in increasing order; n comes from the coach_count register
// input channel: i_valid / o_ready carry one target number and a last flag per
// transfer; the sequence ends on the transfer with i_last high
// output channel: o_valid / i_ready carry o_possible, one verdict per sequence
// configuration: i_cfg_we writes i_cfg_data into coach_count (saturated to
// MAX_ITEMS); write it only while the block is idle
// timing: one target takes 1 cycle to transfer, 1 cycle per item pushed onto
// the stack, 1 cycle for the pop and 1 more to fetch the new top from the
// stack memory when the stack stays non-empty; a sequence of n targets takes
// about 4n cycles, set by the single-port push/pop loop over the stack memory
// a failed sequence skips remaining targets in 1 cycle each
// reset: control state returns to an empty stack, next item 1, coach_count 1;
// the stack memory needs no clearing
// stall: a finished verdict waits in the output register; the block keeps
// taking targets and only holds if a second verdict is ready before the first
// has been taken
module stack_permutation_checker_core
    import stkpc_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  t_val   i_cfg_data,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_val   i_target,
    input  logic   i_last,
    output logic   o_valid,
    input  logic   i_ready,
    output logic   o_possible
);

    localparam int AddrW  = $clog2(MAX_ITEMS);
    localparam int DepthW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FETCH,
        S_WAIT
    } t_state;

    t_state              r_state, n_state;
    logic [DepthW-1:0]   r_depth, n_depth;
    t_nte                r_nte, n_nte;
    logic                r_ok, n_ok;
    t_val                r_top, n_top;
    t_val                r_want, n_want;
    logic                r_last, n_last;
    t_val                r_count, n_count;
    logic                r_verdict, n_verdict;
    logic                r_out_valid, n_out_valid;
    logic                r_possible, n_possible;

    logic                w_push;
    logic                w_rd_en;
    logic                w_done;
    logic                w_verdict;
    logic                w_end;
    logic                w_can_push;
    logic                w_hit;
    logic [AddrW-1:0]    w_rd_addr;
    t_val                w_rd_data;

    assign w_hit      = (r_depth != '0) && (r_top == r_want);
    assign w_can_push = (r_nte <= {1'b0, r_count}) && (r_depth < DepthW'(MAX_ITEMS))
                        && !w_hit;
    assign w_rd_addr  = AddrW'(r_depth - DepthW'(2));

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_nte       = r_nte;
        n_ok        = r_ok;
        n_top       = r_top;
        n_want      = r_want;
        n_last      = r_last;
        n_count     = r_count;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid;
        n_possible  = r_possible;
        w_push      = 1'b0;
        w_rd_en     = 1'b0;
        w_done      = 1'b0;
        w_verdict   = r_ok;
        w_end       = r_last;

        if (i_cfg_we) begin
            if (32'(i_cfg_data) > 32'(MAX_ITEMS)) begin
                n_count = ValW'(MAX_ITEMS);
            end else begin
                n_count = i_cfg_data;
            end
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                w_end = i_last;
                if (i_valid) begin
                    n_want = i_target;
                    n_last = i_last;
                    if (r_ok) begin
                        n_state = S_RUN;
                    end else begin
                        w_done    = 1'b1;
                        w_verdict = 1'b0;
                    end
                end
            end
            S_RUN: begin
                priority if (w_can_push) begin
                    w_push  = 1'b1;
                    n_depth = r_depth + DepthW'(1);
                    n_nte   = r_nte + NteW'(1);
                    n_top   = r_nte[ValW-1:0];
                end else if (w_hit) begin
                    n_depth = r_depth - DepthW'(1);
                    if (r_depth >= DepthW'(2)) begin
                        w_rd_en = 1'b1;
                        n_state = S_FETCH;
                    end else begin
                        w_done = 1'b1;
                    end
                end else begin
                    n_ok      = 1'b0;
                    w_done    = 1'b1;
                    w_verdict = 1'b0;
                end
            end
            S_FETCH: begin
                n_top  = w_rd_data;
                w_done = 1'b1;
            end
            S_WAIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_possible  = r_verdict;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_done) begin
            if (w_end) begin
                n_depth = '0;
                n_nte   = NteW'(1);
                n_ok    = 1'b1;
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_possible  = w_verdict;
                    n_state     = S_IDLE;
                end else begin
                    n_verdict = w_verdict;
                    n_state   = S_WAIT;
                end
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_nte       <= NteW'(1);
            r_ok        <= 1'b1;
            r_count     <= ValW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_nte       <= n_nte;
            r_ok        <= n_ok;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_top      <= n_top;
        r_want     <= n_want;
        r_last     <= n_last;
        r_verdict  <= n_verdict;
        r_possible <= n_possible;
    end

    stkpc_ram #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (AddrW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (r_depth[AddrW-1:0]),
        .i_wr_data (r_nte[ValW-1:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_possible = r_possible;

endmodule

// ----- hdl/stkpc_checker.sv -----
module stkpc_checker
    import stkpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_ready,
    input  logic i_last,
    input  logic o_valid,
    input  logic i_ready,
    input  logic o_possible
);

    // verdict holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_possible))
        else $error("verdict dropped or changed under stall");

    // a waiting target stays offered with its last flag until the transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_last))
        else $error("target withdrawn or changed before transfer");

    // reset leaves no verdict and an open input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("bad state after reset");

    // a new verdict only appears after a transfer with i_last high or with the input busy
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready) || $past(i_valid && i_last))
        else $error("verdict without a last transfer");

endmodule

bind stack_permutation_checker_core stkpc_checker u_stkpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_last     (i_last),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_possible (o_possible)
);

// ----- dv/stkpc_verdict_checker.sv -----
`timescale 1ns / 100ps

module stkpc_verdict_checker
    import stkpc_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  t_val i_cfg_data,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_val i_target,
    input  logic i_last,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  logic i_possible,
    output int   o_mismatches,
    output int   o_verdicts_open
);

    t_val coach_n;
    t_val lifo [MAX_ITEMS];
    int   lifo_depth;
    int   next_in;
    bit   order_ok;
    bit   verdicts [$];

    function automatic void restart_order();
        lifo_depth = 0;
        next_in    = 1;
        order_ok   = 1'b1;
    endfunction

    // push entering items until the wanted one is on top, then pop it
    function automatic void pop_towards(int want);
        int n;
        n = (int'(coach_n) > MAX_ITEMS) ? MAX_ITEMS : int'(coach_n);
        while (next_in <= n && lifo_depth < MAX_ITEMS &&
               (lifo_depth == 0 || int'(lifo[lifo_depth-1]) != want)) begin
            lifo[lifo_depth] = t_val'(next_in);
            lifo_depth++;
            next_in++;
        end
        if (lifo_depth > 0 && int'(lifo[lifo_depth-1]) == want) begin
            lifo_depth--;
        end else begin
            order_ok = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        bit wanted;
        if (!i_rst_n) begin
            coach_n = t_val'(1);
            restart_order();
            verdicts.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                coach_n = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (verdicts.size() == 0) begin
                    $error("possible: expected none, actual %0d", i_possible);
                    o_mismatches++;
                end else begin
                    wanted = verdicts.pop_front();
                    if (i_possible !== wanted) begin
                        $error("possible: expected %0d, actual %0d", wanted, i_possible);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (order_ok) begin
                    pop_towards(int'(i_target));
                end
                if (i_last) begin
                    verdicts.push_back(order_ok);
                    restart_order();
                end
            end
        end
        o_verdicts_open = verdicts.size();
    end

endmodule

// ----- dv/tb_stack_permutation_checker_core.sv -----
`timescale 1ns / 100ps

module tb_stack_permutation_checker_core;
    import stkpc_pkg::*;

    localparam int MaxItems     = 1024;
    localparam int SettleCycles = 4 * MaxItems + 64;
    localparam int RandomItems  = 750;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_val i_cfg_data;
    logic i_valid;
    logic o_ready;
    t_val i_target;
    logic i_last;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_possible;

    int mismatches;
    int verdicts_open;
    bit steady;
    int sent;
    int seq_targets [$];

    stack_permutation_checker_core #(
        .MAX_ITEMS (MaxItems)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_target   (i_target),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_possible (o_possible)
    );

    stkpc_verdict_checker #(
        .MAX_ITEMS (MaxItems)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_target        (i_target),
        .i_last          (i_last),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_possible      (o_possible),
        .o_mismatches    (mismatches),
        .o_verdicts_open (verdicts_open)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb_stack_permutation_checker_core NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_target(int want, bit is_last);
        steady = (sent >= 260 && sent < 400);
        if (!steady) begin
            while ($urandom_range(0, 99) < 36) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid  <= 1'b1;
        i_target <= t_val'(want);
        i_last   <= is_last;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic run_sequence();
        for (int i = 0; i < seq_targets.size(); i++) begin
            send_target(seq_targets[i], i == seq_targets.size() - 1);
        end
    endtask

    // wait for every verdict, then give a trailing target time to finish
    task automatic settle();
        i_valid <= 1'b0;
        wait (verdicts_open == 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_count(int n);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= t_val'(n);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random achievable exit order of 1..n, cut after cap targets
    task automatic build_exit_order(int n, int cap);
        int nxt;
        int held [$];
        nxt = 1;
        seq_targets.delete();
        while (seq_targets.size() < cap && (nxt <= n || held.size() > 0)) begin
            if (held.size() == 0 || (nxt <= n && $urandom_range(0, 1) == 1)) begin
                held.push_back(nxt);
                nxt++;
            end else begin
                seq_targets.push_back(held.pop_back());
            end
        end
    endtask

    initial begin : stimulus
        int pick;
        int n;
        int eff;
        int cap;
        int seqs;
        int keep;
        int len;
        bit big;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_target   <= '0;
        i_last     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n    <= 1'b1;

        // count 1 from reset, out of range and too many targets
        seq_targets = '{1};
        run_sequence();
        seq_targets = '{0};
        run_sequence();
        seq_targets = '{2};
        run_sequence();
        seq_targets = '{1, 1};
        run_sequence();

        // count zero
        settle();
        write_count(0);
        seq_targets = '{0};
        run_sequence();
        seq_targets = '{1};
        run_sequence();

        // count saturated to the stack size, deepest stack
        settle();
        write_count(2047);
        seq_targets = '{1024, 1023};
        run_sequence();
        seq_targets = '{1025};
        run_sequence();
        seq_targets = '{2047};
        run_sequence();

        settle();
        write_count(1024);
        seq_targets = '{1024, 1};
        run_sequence();

        settle();
        write_count(3);
        seq_targets = '{3, 2, 1};
        run_sequence();
        seq_targets = '{3, 1, 2};
        run_sequence();
        seq_targets = '{1, 2};
        run_sequence();

        // count raised in the middle of a sequence
        send_target(2, 1'b0);
        settle();
        write_count(5);
        seq_targets = '{5, 4, 3, 1};
        run_sequence();

        sent = 0;
        while (sent < RandomItems) begin
            pick = $urandom_range(0, 99);
            big  = 1'b0;
            if (pick < 5) begin
                n = 0;
            end else if (pick < 11) begin
                big = 1'b1;
                case ($urandom_range(0, 3))
                    0: n = 1024;
                    1: n = 2047;
                    2: n = $urandom_range(1025, 2047);
                    default: n = $urandom_range(17, 1023);
                endcase
            end else begin
                n = $urandom_range(1, 16);
            end
            eff = (n > MaxItems) ? MaxItems : n;
            settle();
            write_count(n);
            seqs = big ? 1 : $urandom_range(3, 10);
            repeat (seqs) begin
                cap  = big ? $urandom_range(1, 20) : eff;
                pick = $urandom_range(0, 99);
                build_exit_order(eff, cap);
                if (pick < 60) begin
                end else if (pick < 70) begin
                    if (seq_targets.size() > 1) begin
                        keep = $urandom_range(1, seq_targets.size());
                        while (seq_targets.size() > keep) void'(seq_targets.pop_back());
                    end
                end else if (pick < 78) begin
                    seq_targets.push_back($urandom_range(0, eff + 1));
                end else if (pick < 90) begin
                    if (seq_targets.size() > 0) begin
                        keep = $urandom_range(0, seq_targets.size() - 1);
                        seq_targets[keep] = $urandom_range(0, 1) ?
                            $urandom_range(0, 2047) : $urandom_range(0, eff + 1);
                    end
                end else begin
                    seq_targets.delete();
                    len = $urandom_range(1, big ? 20 : eff + 2);
                    repeat (len) begin
                        seq_targets.push_back($urandom_range(0, 1) ?
                            $urandom_range(0, 2047) : $urandom_range(0, eff + 1));
                    end
                end
                if (seq_targets.size() == 0) begin
                    seq_targets.push_back($urandom_range(0, 2047));
                end
                run_sequence();
            end
        end

        settle();
        if (mismatches == 0 && verdicts_open == 0) begin
            $display("tb_stack_permutation_checker_core OK");
        end else begin
            $display("tb_stack_permutation_checker_core NOT OK");
        end
        $finish;
    end

endmodule
